// ----- rtl/core/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg
// shared types and constants for the segment closest point block
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned DiffW  = CoordW + 1;
	localparam int unsigned ProdW  = 2 * DiffW;
	localparam int unsigned DenW   = ProdW + 2;
	localparam int unsigned NumW   = DenW + 1;
	localparam int unsigned TFrac  = 16;
	localparam int unsigned TW     = TFrac + 1;
	localparam int unsigned IdxW   = 3;

	localparam logic [IdxW-1:0] REG_START_X = 3'd0;
	localparam logic [IdxW-1:0] REG_START_Y = 3'd1;
	localparam logic [IdxW-1:0] REG_START_Z = 3'd2;
	localparam logic [IdxW-1:0] REG_END_X   = 3'd3;
	localparam logic [IdxW-1:0] REG_END_Y   = 3'd4;
	localparam logic [IdxW-1:0] REG_END_Z   = 3'd5;

	localparam logic [TW-1:0] T_ONE = TW'(1) << TFrac;

	typedef struct packed {
		logic            vld;
		logic            done;
		logic            degen;
		logic [NumW-1:0] rem;
		logic [DenW-1:0] den;
		logic [TW-1:0]   t;
	} spc_div_t;

endpackage

// ----- rtl/core/spc_div_cell.sv -----
// ----------------------------------------------------------------------------
// spc_div_cell
// one restoring division step per cell, registered toward the next cell
// ----------------------------------------------------------------------------
module spc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  spc_pkg::spc_div_t din,
	output spc_pkg::spc_div_t dout
);

	logic [spc_pkg::NumW-1:0] shl;
	logic                     ge;
	spc_pkg::spc_div_t        nxt;
	logic                     vld_q;
	logic                     done_q;
	logic                     degen_q;
	logic [spc_pkg::NumW-1:0] rem_q;
	logic [spc_pkg::DenW-1:0] den_q;
	logic [spc_pkg::TW-1:0]   t_q;

	always_comb begin
		shl = {din.rem[spc_pkg::NumW-2:0], 1'b0};
		ge  = shl >= {1'b0, din.den};
		nxt = din;
		if (!din.done) begin
			nxt.rem = ge ? shl - {1'b0, din.den} : shl;
			nxt.t   = {din.t[spc_pkg::TW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			done_q  <= nxt.done;
			degen_q <= nxt.degen;
			rem_q   <= nxt.rem;
			den_q   <= nxt.den;
			t_q     <= nxt.t;
		end
	end

	always_comb begin
		dout.vld   = vld_q;
		dout.done  = done_q;
		dout.degen = degen_q;
		dout.rem   = rem_q;
		dout.den   = den_q;
		dout.t     = t_q;
	end

endmodule

// ----- rtl/core/segment_closest_point_top.sv -----
// ----------------------------------------------------------------------------
// segment_closest_point_top
// closest point on a 3d segment to a query point, Q16.16 fixed point
// ----------------------------------------------------------------------------
// usage:
//   write the segment endpoints through cfg_we/cfg_index/cfg_data while the
//   block is idle (index 0..2 start xyz, 3..5 end xyz, others ignored).
//   query transactions enter on query_valid/query_stall, results leave on
//   near_valid/near_stall with near_x/y/z, param_t (Q1.16) and degenerate.
// throughput: one query per cycle while the output is not stalled; the
//   divider is a row of 16 cells, one quotient bit per cell, so 16 queries
//   are in division at once.
// reset: endpoints clear to zero, all stage valids clear, no result pending.
// stall: a stalled result holds the whole pipeline; query_stall is raised
//   while the output register is full and stalled, so nothing is dropped.
// ----------------------------------------------------------------------------
module segment_closest_point_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [spc_pkg::IdxW-1:0]         cfg_index,
	input  logic [spc_pkg::CoordW-1:0]       cfg_data,
	input  logic                             query_valid,
	output logic                             query_stall,
	input  logic signed [spc_pkg::CoordW-1:0] query_x,
	input  logic signed [spc_pkg::CoordW-1:0] query_y,
	input  logic signed [spc_pkg::CoordW-1:0] query_z,
	output logic                             near_valid,
	input  logic                             near_stall,
	output logic signed [spc_pkg::CoordW-1:0] near_x,
	output logic signed [spc_pkg::CoordW-1:0] near_y,
	output logic signed [spc_pkg::CoordW-1:0] near_z,
	output logic [spc_pkg::TW-1:0]           param_t,
	output logic                             degenerate
);

	localparam int unsigned CW = spc_pkg::CoordW;
	localparam int unsigned DW = spc_pkg::DiffW;
	localparam int unsigned PW = spc_pkg::ProdW;
	localparam int unsigned LW = DW + spc_pkg::TW + 1;

	logic signed [CW-1:0] start_q [3];
	logic signed [CW-1:0] end_q [3];
	logic signed [CW-1:0] qry [3];
	logic signed [DW-1:0] dir [3];
	logic                 en;

	logic                 vld_s1, vld_s2, vld_s4, vld_q;
	logic signed [DW-1:0] v_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic signed [PW-1:0] vd_s2 [3];
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [spc_pkg::NumW-1:0] num;
	logic [spc_pkg::DenW-1:0]        den;
	spc_pkg::spc_div_t               head;
	spc_pkg::spc_div_t               chain [spc_pkg::TFrac+1];
	logic signed [LW-1:0] p_s4 [3];
	logic [spc_pkg::TW-1:0] t_s4;
	logic                   degen_s4;
	logic signed [CW-1:0]   near_q [3];
	logic [spc_pkg::TW-1:0] t_q;
	logic                   degen_q;

	assign en          = !(vld_q && near_stall);
	assign query_stall = vld_q && near_stall;
	assign qry[0] = query_x;
	assign qry[1] = query_y;
	assign qry[2] = query_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				end_q[i]   <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				spc_pkg::REG_START_X: start_q[0] <= cfg_data;
				spc_pkg::REG_START_Y: start_q[1] <= cfg_data;
				spc_pkg::REG_START_Z: start_q[2] <= cfg_data;
				spc_pkg::REG_END_X:   end_q[0]   <= cfg_data;
				spc_pkg::REG_END_Y:   end_q[1]   <= cfg_data;
				spc_pkg::REG_END_Z:   end_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir[i] = DW'(end_q[i]) - DW'(start_q[i]);
		end
	end

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= query_valid;
			vld_s2 <= vld_s1;
			vld_s4 <= chain[spc_pkg::TFrac].vld;
			vld_q  <= vld_s4;
		end
	end

	// offsets and products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i]  <= DW'(qry[i]) - DW'(start_q[i]);
				d_s1[i]  <= dir[i];
				vd_s2[i] <= v_s1[i] * d_s1[i];
				dd_s2[i] <= d_s1[i] * d_s1[i];
			end
		end
	end

	// dot products and the cases that need no division
	always_comb begin
		num = spc_pkg::NumW'(vd_s2[0]) + spc_pkg::NumW'(vd_s2[1])
			+ spc_pkg::NumW'(vd_s2[2]);
		den = spc_pkg::DenW'(dd_s2[0]) + spc_pkg::DenW'(dd_s2[1])
			+ spc_pkg::DenW'(dd_s2[2]);
		head.vld   = vld_s2;
		head.degen = (den == '0);
		head.rem   = num;
		head.den   = den;
		head.t     = '0;
		head.done  = 1'b1;
		if (head.degen || num[spc_pkg::NumW-1] || num == '0) begin
			head.t = '0;
		end else if (num >= $signed({1'b0, den})) begin
			head.t = spc_pkg::T_ONE;
		end else begin
			head.done = 1'b0;
		end
	end

	assign chain[0] = head;

	for (genvar g = 0; g < spc_pkg::TFrac; g++) begin : g_cell
		spc_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.din   (chain[g]),
			.dout  (chain[g+1])
		);
	end

	// interpolation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= LW'(dir[i]) * $signed({1'b0, chain[spc_pkg::TFrac].t});
			end
			t_s4     <= chain[spc_pkg::TFrac].t;
			degen_s4 <= chain[spc_pkg::TFrac].degen;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				near_q[i] <= start_q[i] + CW'((p_s4[i]
					+ (LW'(1) <<< (spc_pkg::TFrac - 1))) >>> spc_pkg::TFrac);
			end
			t_q     <= t_s4;
			degen_q <= degen_s4;
		end
	end

	assign near_valid = vld_q;
	assign near_x     = near_q[0];
	assign near_y     = near_q[1];
	assign near_z     = near_q[2];
	assign param_t    = t_q;
	assign degenerate = degen_q;

`ifndef ASSERT_OFF
	a_degen_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(near_valid && degenerate) |-> (param_t == '0))
		else $error("degenerate result with nonzero t");
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		near_valid |-> (param_t <= spc_pkg::T_ONE))
		else $error("t above one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(near_valid && near_stall) |=> (near_valid && $stable(near_x) && $stable(param_t)))
		else $error("stalled result changed");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> (near_valid && near_stall))
		else $error("input stalled without output stall");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives query transactions through segment_closest_point_top under random
// gaps and output stalls, across several segment settings (random, short,
// zero length, extreme corners, axis aligned), and checks every result field
// against an independent fixed point prediction of the closest point
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic signed [spc_pkg::CoordW-1:0] nx;
		logic signed [spc_pkg::CoordW-1:0] ny;
		logic signed [spc_pkg::CoordW-1:0] nz;
		logic [spc_pkg::TW-1:0]            t;
		logic                              degen;
	} near_point_t;

	class closest_point_board;
		logic signed [spc_pkg::CoordW-1:0] seg[6];
		near_point_t pending[$];
		int errors;

		function new();
			foreach (seg[i]) seg[i] = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [spc_pkg::IdxW-1:0] idx,
				logic [spc_pkg::CoordW-1:0] val);
			if (idx <= spc_pkg::REG_END_Z) seg[idx] = val;
		endfunction

		function near_point_t project(logic signed [spc_pkg::CoordW-1:0] q[3]);
			logic signed [127:0] s[3], d[3], v[3];
			logic signed [127:0] num, den, quo, tw;
			logic signed [127:0] c[3];
			near_point_t r;
			for (int i = 0; i < 3; i++) begin
				s[i] = seg[i];
				c[i] = seg[i+3];
				d[i] = c[i] - s[i];
				c[i] = q[i];
				v[i] = c[i] - s[i];
			end
			num = v[0]*d[0] + v[1]*d[1] + v[2]*d[2];
			den = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
			r.degen = (den == 0);
			if (r.degen || num <= 0) r.t = '0;
			else if (num >= den) r.t = spc_pkg::T_ONE;
			else begin
				quo = (num <<< spc_pkg::TFrac) / den;
				r.t = quo[spc_pkg::TW-1:0];
			end
			tw = '0;
			tw[spc_pkg::TW-1:0] = r.t;
			for (int i = 0; i < 3; i++)
				c[i] = s[i] + ((d[i] * tw + 128'sd32768) >>> spc_pkg::TFrac);
			r.nx = c[0][spc_pkg::CoordW-1:0];
			r.ny = c[1][spc_pkg::CoordW-1:0];
			r.nz = c[2][spc_pkg::CoordW-1:0];
			return r;
		endfunction

		function void note_query(logic signed [spc_pkg::CoordW-1:0] q[3]);
			pending.push_back(project(q));
		endfunction

		function void check_result(near_point_t got);
			near_point_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result x %h y %h z %h t %h", $time,
					got.nx, got.ny, got.nz, got.t);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.nx !== e.nx) begin
				$display("%0t near_x exp %h got %h", $time, e.nx, got.nx);
				errors++;
			end
			if (got.ny !== e.ny) begin
				$display("%0t near_y exp %h got %h", $time, e.ny, got.ny);
				errors++;
			end
			if (got.nz !== e.nz) begin
				$display("%0t near_z exp %h got %h", $time, e.nz, got.nz);
				errors++;
			end
			if (got.t !== e.t) begin
				$display("%0t param_t exp %h got %h", $time, e.t, got.t);
				errors++;
			end
			if (got.degen !== e.degen) begin
				$display("%0t degenerate exp %b got %b", $time, e.degen, got.degen);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [spc_pkg::IdxW-1:0] cfg_index;
	logic [spc_pkg::CoordW-1:0] cfg_data;
	logic query_valid, query_stall;
	logic signed [spc_pkg::CoordW-1:0] query_x, query_y, query_z;
	logic near_valid, near_stall;
	logic signed [spc_pkg::CoordW-1:0] near_x, near_y, near_z;
	logic [spc_pkg::TW-1:0] param_t;
	logic degenerate;

	closest_point_board board;
	int stall_mode;
	logic signed [spc_pkg::CoordW-1:0] seg_now[6];

	segment_closest_point_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.query_valid(query_valid), .query_stall(query_stall),
		.query_x(query_x), .query_y(query_y), .query_z(query_z),
		.near_valid(near_valid), .near_stall(near_stall),
		.near_x(near_x), .near_y(near_y), .near_z(near_z),
		.param_t(param_t), .degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output side: sample at the rising edge, change stall at the falling edge
	initial begin
		near_point_t got;
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && near_valid && !near_stall) begin
				got.nx = near_x;
				got.ny = near_y;
				got.nz = near_z;
				got.t = param_t;
				got.degen = degenerate;
				board.check_result(got);
			end
			@(negedge clk);
			if (hold > 0) hold--;
			else if (stall_mode == 0) near_stall = 1'b0;
			else begin
				near_stall = ($urandom_range(0, 99) < 30);
				if ($urandom_range(0, 99) < 4) begin
					near_stall = 1'b1;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	task automatic write_reg(logic [spc_pkg::IdxW-1:0] idx,
			logic [spc_pkg::CoordW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic load_segment(logic signed [spc_pkg::CoordW-1:0] v[6]);
		for (int i = 0; i < 6; i++) write_reg(i[spc_pkg::IdxW-1:0], v[i]);
		if ($urandom_range(0, 1))
			write_reg(3'd6 + spc_pkg::IdxW'($urandom_range(0, 1)), $urandom);
		@(negedge clk);
		cfg_we = 1'b0;
		seg_now = v;
	endtask

	task automatic send_query(logic signed [spc_pkg::CoordW-1:0] x,
			logic signed [spc_pkg::CoordW-1:0] y,
			logic signed [spc_pkg::CoordW-1:0] z, int gap);
		logic signed [spc_pkg::CoordW-1:0] q[3];
		if (gap > 0) begin
			@(negedge clk);
			query_valid = 1'b0;
			repeat (gap) @(posedge clk);
		end
		@(negedge clk);
		query_valid = 1'b1;
		query_x = x;
		query_y = y;
		query_z = z;
		do @(posedge clk); while (query_stall);
		q[0] = x;
		q[1] = y;
		q[2] = z;
		board.note_query(q);
	endtask

	task automatic drain();
		@(negedge clk);
		query_valid = 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// query near the segment: start + d*k/256 plus a little noise
	function automatic logic signed [spc_pkg::CoordW-1:0] along(int i, int k);
		logic signed [63:0] s, d, n;
		s = seg_now[i];
		d = seg_now[i+3];
		d = d - s;
		n = $signed($urandom_range(0, 2047)) - 1024;
		return spc_pkg::CoordW'(s + ((d * k) >>> 8) + n);
	endfunction

	function automatic logic signed [spc_pkg::CoordW-1:0] rand_coord(int mode);
		case (mode)
			1: return spc_pkg::CoordW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			4: return $urandom_range(0, 1) ? 32'sh0 : $urandom;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic signed [spc_pkg::CoordW-1:0] v[6];
		int mode, k;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		query_valid = 1'b0;
		query_x = '0;
		query_y = '0;
		query_z = '0;
		near_stall = 1'b0;
		stall_mode = 0;
		foreach (seg_now[i]) seg_now[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero length segment after reset
		send_query(32'sh7fffffff, 32'sh80000000, 32'sh0, 0);
		send_query(32'sh80000000, 32'sh7fffffff, 32'sh12345678, 0);
		drain();

		// extreme diagonal, queries at both ends, the middle and off the line
		v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
		load_segment(v);
		send_query(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
		send_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
		send_query(32'sh0, 32'sh0, 32'sh0, 0);
		send_query(32'sh7fffffff, 32'sh80000000, 32'sh0, 1);
		send_query(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);
		drain();
		v = '{32'sh00010000, 32'sh0, 32'sh0, 32'sh00050000, 32'sh0, 32'sh0};
		load_segment(v);
		send_query(32'sh00000000, 32'sh00030000, 32'sh0, 0);
		send_query(32'sh00090000, 32'shfffd0000, 32'sh0, 0);
		send_query(32'sh00030000, 32'sh7fffffff, 32'sh80000000, 0);
		send_query(32'sh00010001, 32'sh0, 32'sh0, 0);
		send_query(32'sh0004ffff, 32'sh0, 32'sh0, 0);
		send_query(32'sh00050000, 32'sh0, 32'sh0, 0);
		drain();
		// degenerate away from origin
		v = '{32'sh7fffffff, 32'sh80000000, 32'sh00001234,
			32'sh7fffffff, 32'sh80000000, 32'sh00001234};
		load_segment(v);
		send_query(32'sh0, 32'sh0, 32'sh0, 0);
		send_query(32'shffffffff, 32'sh7fffffff, 32'sh80000000, 0);
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			mode = ph % 5;
			for (int i = 0; i < 3; i++) begin
				v[i] = rand_coord(mode);
				v[i+3] = (mode == 2) ? v[i] : rand_coord(mode);
			end
			if (mode == 4) begin
				k = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++) if (i != k) v[i+3] = v[i];
			end
			load_segment(v);
			stall_mode = (ph % 4 == 3) ? 0 : 1;
			for (int n = 0; n < 128; n++) begin
				if ($urandom_range(0, 99) < 70) begin
					k = $signed($urandom_range(0, 320)) - 32;
					send_query(along(0, k), along(1, k), along(2, k),
						stall_mode ? gap_len() : 0);
				end else begin
					send_query($urandom, $urandom, $urandom, stall_mode ? gap_len() : 0);
				end
			end
			drain();
		end
		stall_mode = 0;

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
